/* hdl/mbrot_pkg.sv */
// ============================================================================
// mbrot_pkg
// Shared types and constants for the escape-time iteration and coloring block.
// ============================================================================
package mbrot_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;

    localparam t_cfg_index CFG_MAX_ITERATIONS = 2'd0;
    localparam t_cfg_index CFG_GRADIENT_START = 2'd1;
    localparam t_cfg_index CFG_GRADIENT_END   = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_MAX_ITERATIONS = 16'd100;
    localparam logic [23:0] RST_GRADIENT_START = 24'h3D7EAA;
    localparam logic [23:0] RST_GRADIENT_END   = 24'hFFE47A;

    // Product selector of the shared multiplier
    typedef logic [1:0] t_prod_sel;
    localparam t_prod_sel PROD_XX = 2'd0;
    localparam t_prod_sel PROD_YY = 2'd1;
    localparam t_prod_sel PROD_XY = 2'd2;

    // Color channel selector
    typedef logic [1:0] t_chan_sel;
    localparam t_chan_sel CH_RED   = 2'd0;
    localparam t_chan_sel CH_GREEN = 2'd1;
    localparam t_chan_sel CH_BLUE  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DRAIN,
        S_UPDATE,
        S_DIV,
        S_COLOR
    } t_state;

endpackage

/* hdl/mandelbrot_escape_time_color_top.sv */
// ============================================================================
// mandelbrot_escape_time_color_top
// Escape-time iteration of z = z*z + c with gradient coloring of the count.
// ============================================================================
//
//  Channel   Ports                                        Handshake
//  --------  -------------------------------------------  -------------------------
//  request   start, i_c_real, i_c_imag, busy              taken when start & !busy
//  result    o_done, o_iteration_count, o_escaped,        o_done high one cycle
//            o_red, o_green, o_blue
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_data         written when i_cfg_wr_en
//
//  One request at a time. Each iteration passes the check, multiply, drain
//  and update states; D = 1 for FRAC_BITS up to 30 and D = 2 above: the single
//  shared multiplier forms |x|*|x|, |y|*|y| and |x|*|y| one after the other,
//  D*D digit products each. An inside point ends at a final check; an escaped
//  point then goes through the bit-serial index divider and the color step.
//  Reset is synchronous and active low; it restores the register defaults.
//  The result is held on the outputs; o_done marks it for one cycle and the
//  receiver cannot stall it. busy drops in the same cycle as o_done rises.
//
module mandelbrot_escape_time_color_top #(
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      i_c_real,
    input  logic signed [31:0]      i_c_imag,
    // result
    output logic                    o_done,
    output logic [15:0]             o_iteration_count,
    output logic                    o_escaped,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  mbrot_pkg::t_cfg_index   i_cfg_index,
    input  mbrot_pkg::t_cfg_data    i_cfg_data
);
    import mbrot_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    // magnitude of x or y once it passed the |v| <= 2 check
    localparam int MW   = FRAC_BITS + 2;
    // digits per operand of the shared multiplier, and digit width
    localparam int ND   = (MW > 32) ? 2 : 1;
    localparam int DW   = (MW + ND - 1) / ND;
    localparam int PW   = 2 * DW;
    localparam int AW   = 4 * DW;
    localparam int PRW  = 2 * MW;
    // z register: holds x2 - y2 + c and +-xy + c with margin
    localparam int ZW   = ((FRAC_BITS + 4 > 32) ? FRAC_BITS + 4 : 32) + 2;
    localparam int X2W  = FRAC_BITS + 4;
    localparam int XYW  = FRAC_BITS + 5;
    // divider and limit widths
    localparam int NW   = COUNT_WIDTH + 8;
    localparam int LIMW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam logic [ZW-1:0]   TWO      = ZW'(1) << (FRAC_BITS + 1);
    localparam logic [XYW-1:0]  FOUR     = XYW'(1) << (FRAC_BITS + 2);
    localparam logic [1:0]      DIG_LAST = 2'(ND * ND - 1);
    localparam logic [LIMW-1:0] CMAX     = LIMW'({COUNT_WIDTH{1'b1}});

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [15:0] r_max_iter;
    logic [23:0] r_grad_start;
    logic [23:0] r_grad_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= RST_MAX_ITERATIONS;
            r_grad_start <= RST_GRADIENT_START;
            r_grad_end   <= RST_GRADIENT_END;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_ITERATIONS: r_max_iter   <= i_cfg_data[15:0];
                CFG_GRADIENT_START: r_grad_start <= i_cfg_data;
                CFG_GRADIENT_END:   r_grad_end   <= i_cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------------
    t_state                r_state, n_state;

    logic [31:0]           r_cr, r_ci;
    logic [ZW-1:0]         r_x, r_y;
    logic [COUNT_WIDTH-1:0] r_count, r_lim;
    logic [MW-1:0]         r_ax, r_ay;
    logic                  r_neg;

    // shared multiplier sequencing
    t_prod_sel             r_prod;
    logic [1:0]            r_dig;
    logic [PW-1:0]         r_pp;
    logic [1:0]            r_pp_sh;
    t_prod_sel             r_pp_prod;
    logic                  r_pp_vld;
    logic                  r_pp_last;
    logic [AW-1:0]         r_acc;
    logic [PRW-1:0]        r_p_xx, r_p_yy, r_p_xy;

    // index divider and color step
    logic [NW-1:0]         r_rem;
    logic [2:0]            r_bit;
    logic [7:0]            r_idx;
    t_chan_sel             r_ch;

    // result registers
    logic                  r_done;
    logic [15:0]           r_out_count;
    logic                  r_out_escaped;
    logic [7:0]            r_red, r_green, r_blue;

    // ------------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------------
    // effective limit: saturate to the counter range
    logic [LIMW-1:0] lim_ext;
    logic [LIMW-1:0] lim_eff;
    assign lim_ext = LIMW'(r_max_iter);
    assign lim_eff = (lim_ext > CMAX) ? CMAX : lim_ext;

    // top-of-iteration check
    logic [ZW-1:0] ax, ay;
    logic          chk_run, chk_big;
    assign ax      = r_x[ZW-1] ? (ZW'(0) - r_x) : r_x;
    assign ay      = r_y[ZW-1] ? (ZW'(0) - r_y) : r_y;
    assign chk_run = (r_count < r_lim);
    assign chk_big = (ax > TWO) || (ay > TWO);

    // operand digits for the current product
    logic [PW-1:0] pad_a, pad_b;
    logic [DW-1:0] dig_a, dig_b;
    always_comb begin
        case (r_prod)
            PROD_XX: begin
                pad_a = PW'(r_ax);
                pad_b = PW'(r_ax);
            end
            PROD_YY: begin
                pad_a = PW'(r_ay);
                pad_b = PW'(r_ay);
            end
            default: begin
                pad_a = PW'(r_ax);
                pad_b = PW'(r_ay);
            end
        endcase
    end
    assign dig_a = r_dig[1] ? pad_a[DW +: DW] : pad_a[0 +: DW];
    assign dig_b = r_dig[0] ? pad_b[DW +: DW] : pad_b[0 +: DW];

    // align the registered digit product and add it in
    logic [AW-1:0] pp_aligned, acc_sum;
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_aligned = AW'(r_pp);
            2'd1:    pp_aligned = AW'(r_pp) << DW;
            default: pp_aligned = AW'(r_pp) << (2 * DW);
        endcase
    end
    assign acc_sum = r_acc + pp_aligned;

    // z update from the three truncated products
    logic [X2W-1:0] x2, y2;
    logic [XYW-1:0] xy;
    logic [ZW-1:0]  xy_mag, xy_signed, cr_ext, ci_ext, x_new, y_new;
    logic           upd_esc;
    assign x2        = r_p_xx[PRW-1:FRAC_BITS];
    assign y2        = r_p_yy[PRW-1:FRAC_BITS];
    assign xy        = r_p_xy[PRW-1:FRAC_BITS-1];
    assign upd_esc   = (XYW'(x2) + XYW'(y2)) > FOUR;
    assign xy_mag    = ZW'(xy);
    assign xy_signed = r_neg ? (ZW'(0) - xy_mag) : xy_mag;
    assign cr_ext    = {{(ZW-32){r_cr[31]}}, r_cr};
    assign ci_ext    = {{(ZW-32){r_ci[31]}}, r_ci};
    assign x_new     = ZW'(x2) - ZW'(y2) + cr_ext;
    assign y_new     = xy_signed + ci_ext;

    // index divider: one quotient bit per cycle, most significant first
    logic [NW-1:0] div_num, div_trial;
    logic          div_ge;
    assign div_num   = {r_count, 8'd0} - NW'(r_count);
    assign div_trial = NW'(r_lim) << r_bit;
    assign div_ge    = (r_rem >= div_trial);

    // one color channel: (s*256 + (e - s)*idx + 128) >> 8
    logic [7:0]         col_s, col_e;
    logic signed [8:0]  col_diff;
    logic signed [9:0]  col_idx;
    logic signed [18:0] col_prod, col_sum;
    always_comb begin
        case (r_ch)
            CH_RED: begin
                col_s = r_grad_start[23:16];
                col_e = r_grad_end[23:16];
            end
            CH_GREEN: begin
                col_s = r_grad_start[15:8];
                col_e = r_grad_end[15:8];
            end
            default: begin
                col_s = r_grad_start[7:0];
                col_e = r_grad_end[7:0];
            end
        endcase
    end
    assign col_diff = $signed({1'b0, col_e}) - $signed({1'b0, col_s});
    assign col_idx  = $signed({2'b00, r_idx});
    assign col_prod = col_diff * col_idx;
    assign col_sum  = $signed({3'b000, col_s, 8'd0}) + col_prod + 19'sd128;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!chk_run)     n_state = S_IDLE;
                else if (chk_big) n_state = S_DIV;
                else              n_state = S_MUL;
            end
            S_MUL: begin
                if (r_dig == DIG_LAST && r_prod == PROD_XY) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = upd_esc ? S_DIV : S_CHECK;
            end
            S_DIV: begin
                if (r_bit == 3'd0) n_state = S_COLOR;
            end
            S_COLOR: begin
                if (r_ch == CH_BLUE) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod    <= PROD_XX;
            r_dig     <= 2'd0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_bit     <= 3'd0;
            r_ch      <= CH_RED;
            r_done    <= 1'b0;
        end else begin
            // strobe the result when the limit is reached or the last channel lands
            r_done    <= ((r_state == S_CHECK) && !chk_run) ||
                         ((r_state == S_COLOR) && (r_ch == CH_BLUE));
            r_pp_vld  <= (r_state == S_MUL);
            r_pp_last <= (r_state == S_MUL) && (r_dig == DIG_LAST);
            case (r_state)
                S_CHECK: begin
                    r_prod <= PROD_XX;
                    r_dig  <= 2'd0;
                    r_bit  <= 3'd7;
                end
                S_MUL: begin
                    // advance digit pair, then product
                    if (r_dig == DIG_LAST) begin
                        r_dig  <= 2'd0;
                        r_prod <= t_prod_sel'(r_prod + 2'd1);
                    end else begin
                        r_dig  <= r_dig + 2'd1;
                    end
                end
                S_UPDATE: begin
                    r_bit <= 3'd7;
                end
                S_DIV: begin
                    r_bit <= r_bit - 3'd1;
                    r_ch  <= CH_RED;
                end
                S_COLOR: begin
                    r_ch <= t_chan_sel'(r_ch + 2'd1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // shared multiplier: digit product, then registered accumulate
        r_pp      <= dig_a * dig_b;
        r_pp_sh   <= 2'(r_dig[1] + r_dig[0]);
        r_pp_prod <= r_prod;

        if (r_pp_vld) begin
            if (r_pp_last) begin
                r_acc <= '0;
                case (r_pp_prod)
                    PROD_XX: r_p_xx <= acc_sum[PRW-1:0];
                    PROD_YY: r_p_yy <= acc_sum[PRW-1:0];
                    default: r_p_xy <= acc_sum[PRW-1:0];
                endcase
            end else begin
                r_acc <= acc_sum;
            end
        end else if (r_state == S_CHECK) begin
            r_acc <= '0;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_cr    <= i_c_real;
                    r_ci    <= i_c_imag;
                    r_x     <= '0;
                    r_y     <= '0;
                    r_count <= '0;
                    r_lim   <= lim_eff[COUNT_WIDTH-1:0];
                end
            end
            S_CHECK: begin
                r_ax    <= ax[MW-1:0];
                r_ay    <= ay[MW-1:0];
                r_neg   <= r_x[ZW-1] ^ r_y[ZW-1];
                r_rem   <= div_num;
                r_idx   <= 8'd0;
                r_out_count   <= 16'(r_count);
                r_out_escaped <= chk_run;
                if (!chk_run) begin
                    // limit reached: inside the set, black
                    r_red   <= 8'd0;
                    r_green <= 8'd0;
                    r_blue  <= 8'd0;
                end
            end
            S_UPDATE: begin
                r_rem         <= div_num;
                r_idx         <= 8'd0;
                r_out_count   <= 16'(r_count);
                r_out_escaped <= 1'b1;
                if (!upd_esc) begin
                    r_x     <= x_new;
                    r_y     <= y_new;
                    r_count <= r_count + COUNT_WIDTH'(1);
                end
            end
            S_DIV: begin
                if (div_ge) r_rem <= r_rem - div_trial;
                r_idx <= {r_idx[6:0], div_ge};
            end
            S_COLOR: begin
                case (r_ch)
                    CH_RED:   r_red   <= col_sum[15:8];
                    CH_GREEN: r_green <= col_sum[15:8];
                    default:  r_blue  <= col_sum[15:8];
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_iteration_count = r_out_count;
    assign o_escaped         = r_out_escaped;
    assign o_red             = r_red;
    assign o_green           = r_green;
    assign o_blue            = r_blue;

endmodule
